// File: rtl/core/lsf_pkg.sv
`timescale 1ns / 1ps
// Package for the line substring filter: sizes, config register indexes,
// the step/result structs shared by the line control and the top level, and the case fold.
// No dependencies.
package lsf_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LEN_CAP     = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
    localparam int LEN_W       = 5;
    localparam int SLOT_W      = $clog2(PATTERN_MAX);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CNT_W       = 32;
    localparam int OUT_DATA_W  = 72;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_PAT_LEN = 3'd2,
        CFG_NOCASE  = 3'd3,
        CFG_INVERT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic is_newline;
        logic last;
        logic window_hit;
    } t_step;

    typedef struct packed {
        logic [CNT_W-1:0] line_index;
        logic             line_selected;
        logic [CNT_W-1:0] selected_total;
        logic             stream_done;
        logic             any_selected;
    } t_result;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/lsf_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one recent byte of the line and its valid bit,
// compares the byte entering it (from its neighbor, or the input byte for cell 0) against its pattern byte.
// Depends on lsf_pkg.
module lsf_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic       i_fold,
    input  logic       i_in_use,
    input  logic [7:0] i_pat_byte,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output logic       o_hit
);
    import lsf_pkg::*;

    logic [7:0] r_byte;
    logic       r_valid;

    assign o_hit   = !i_in_use
                     || (i_valid && fold_byte(i_byte, i_fold) == fold_byte(i_pat_byte, i_fold));
    assign o_byte  = r_byte;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: rtl/core/lsf_line_ctrl.sv
`timescale 1ns / 1ps
// Line control: match flag, line number and selected-line count;
// forms the result at each line end.
// Depends on lsf_pkg.
module lsf_line_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsf_pkg::t_step   i_step,
    input  logic             i_len_zero,
    input  logic             i_invert,
    output lsf_pkg::t_result o_res,
    output logic             o_res_valid
);
    import lsf_pkg::*;

    localparam logic [CNT_W-1:0] ALL_ONES = '1;
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic             r_has_match;
    logic [CNT_W-1:0] r_line;
    logic [CNT_W-1:0] r_total;

    logic             n_has_match;
    logic             line_end;
    logic             sel;
    logic [CNT_W-1:0] n_total;

    always_comb begin
        n_has_match = r_has_match || (i_step.accept && !i_step.is_newline && i_step.window_hit);
        line_end    = i_step.accept && (i_step.is_newline || i_step.last);
        sel         = (n_has_match || i_len_zero) ^ i_invert;
        n_total     = (sel && r_total != ALL_ONES) ? r_total + ONE : r_total;

        o_res.line_index     = r_line;
        o_res.line_selected  = sel;
        o_res.selected_total = n_total;
        o_res.stream_done    = i_step.last;
        o_res.any_selected   = i_step.last && n_total != '0;
        o_res_valid          = line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_match <= 1'b0;
            r_line      <= ONE;
            r_total     <= '0;
        end else if (line_end) begin
            r_has_match <= 1'b0;
            if (i_step.last) begin
                r_line  <= ONE;
                r_total <= '0;
            end else begin
                r_total <= n_total;
                if (r_line != ALL_ONES) begin
                    r_line <= r_line + ONE;
                end
            end
        end else if (i_step.accept) begin
            r_has_match <= n_has_match;
        end
    end

endmodule

// File: rtl/core/line_substring_filter.sv
`timescale 1ns / 1ps
// Top level of the line substring filter: config registers, the window cell chain,
// line control and a two-entry result buffer. Depends on lsf_pkg, lsf_cell, lsf_line_ctrl.
//
// Takes one text byte per cycle, ends a line at a newline or at the byte flagged by tlast,
// and gives one result per line: line number, verdict, running selected count, and on the
// last line of the data whether any line was selected. All window cells compare against
// the pattern in parallel in the cycle the byte enters, and a line's result is registered
// in the output register, or in the skid entry while the output is stalled. The output has
// a skid entry behind it, so input keeps flowing while a result waits; input stalls only
// when both entries hold results. Write config only with no line result outstanding.
module line_substring_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // text_byte
    input  logic                            i_s_axis_tlast,  // final_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // line_index[31:0], line_selected[32], selected_total[64:33], any_selected[65], zero pad
    output logic [lsf_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast   // stream_done
);
    import lsf_pkg::*;

    logic [2*CFG_DATA_W-1:0] r_pattern;
    logic [LEN_W-1:0]        r_len;
    logic                    r_nocase;
    logic                    r_invert;

    logic [LEN_W-1:0]        used_len;
    logic                    accept;
    logic                    is_nl;
    logic                    shift;
    logic                    clear;

    logic [7:0]              cell_byte  [PATTERN_MAX];
    logic                    cell_valid [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]  hit;

    t_step                   step;
    t_result                 res;
    logic                    res_valid;

    t_result                 r_out;
    logic                    r_out_valid;
    t_result                 r_skid;
    logic                    r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
            r_nocase  <= 1'b0;
            r_invert  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAT_LO:  r_pattern[CFG_DATA_W-1:0]            <= i_cfg_data;
                CFG_PAT_HI:  r_pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_PAT_LEN: r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_NOCASE:  r_nocase <= i_cfg_data[0];
                CFG_INVERT:  r_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign used_len        = (r_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : r_len;
    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_nl           = i_s_axis_tdata == NEWLINE_BYTE;
    assign shift           = accept && !is_nl;
    assign clear           = accept && (is_nl || i_s_axis_tlast);

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic [7:0]        in_byte;
        logic              in_valid;
        logic              in_use;
        logic [LEN_W-1:0]  k_full;
        logic [SLOT_W-1:0] k;

        if (g == 0) begin : g_head
            assign in_byte  = i_s_axis_tdata;
            assign in_valid = 1'b1;
        end else begin : g_link
            assign in_byte  = cell_byte[g-1];
            assign in_valid = cell_valid[g-1];
        end

        // pattern's last byte lines up with the newest byte in cell 0
        assign in_use = LEN_W'(g) < used_len;
        assign k_full = used_len - LEN_W'(g) - LEN_W'(1);
        assign k      = k_full[SLOT_W-1:0];

        lsf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (shift),
            .i_clear    (clear),
            .i_fold     (r_nocase),
            .i_in_use   (in_use),
            .i_pat_byte (r_pattern[{k, 3'b000} +: 8]),
            .i_byte     (in_byte),
            .i_valid    (in_valid),
            .o_byte     (cell_byte[g]),
            .o_valid    (cell_valid[g]),
            .o_hit      (hit[g])
        );
    end

    always_comb begin
        step.accept     = accept;
        step.is_newline = is_nl;
        step.last       = i_s_axis_tlast;
        step.window_hit = (&hit) && (used_len != '0);
    end

    lsf_line_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_len_zero  (used_len == '0),
        .i_invert    (r_invert),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.stream_done;
    assign o_m_axis_tdata  = {6'd0, r_out.any_selected, r_out.selected_total,
                              r_out.line_selected, r_out.line_index};

endmodule

// File: rtl/core/lsf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for line_substring_filter, attached by the bind below.
// Depends on lsf_pkg and line_substring_filter.
module lsf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [lsf_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);
    import lsf_pkg::*;

    logic out_acc;
    logic r_first;

    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (out_acc) begin
            r_first <= o_m_axis_tlast;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    a_first_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_first) |-> (o_m_axis_tdata[CNT_W-1:0] == CNT_W'(1)))
        else $error("first line of a stream not numbered one");

    a_any_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2*CNT_W+1]) |-> o_m_axis_tlast)
        else $error("any_selected set outside stream end");

    a_sel_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[CNT_W]) |-> (o_m_axis_tdata[2*CNT_W:CNT_W+1] != '0))
        else $error("selected line with zero total");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
